@@ rtl/rcpw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpw_pkg
// Shared types and constants of the rc pulse width capture block.
// ----------------------------------------------------------------------------
package rcpw_pkg;

  localparam int PIN_BITS = 3;
  localparam int WIDTH_BITS = 15;
  localparam int TS_BITS = 16;
  localparam int OUT_WIDTHS = 3;
  localparam int CFG_ADDR_BITS = 2;

  localparam logic [WIDTH_BITS-1:0] NEUTRAL_RST = 15'd1500;
  localparam logic [WIDTH_BITS-1:0] CLAMP_MIN_RST = 15'd1000;
  localparam logic [WIDTH_BITS-1:0] CLAMP_MAX_RST = 15'd2000;

  // event kind carried on in_tuser
  localparam logic MODE_PIN_CHANGE = 1'b0;
  localparam logic MODE_OVERFLOW = 1'b1;

  // configuration register indexes
  localparam logic [CFG_ADDR_BITS-1:0] CFG_NEUTRAL_WIDTH = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_CLAMP_MIN = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_CLAMP_MAX = 2'd2;

  typedef logic [WIDTH_BITS-1:0] width_t;

  typedef struct packed {
    logic   enabled;
    width_t width_ch2;
    width_t width_ch1;
    width_t width_ch0;
  } result_t;

  localparam int RESULT_BITS = $bits(result_t);
  localparam int OUT_TDATA_BITS = ((RESULT_BITS + 7) / 8) * 8;
  localparam int IN_FIELD_BITS = PIN_BITS + TS_BITS;
  localparam int IN_TDATA_BITS = ((IN_FIELD_BITS + 7) / 8) * 8;

endpackage

@@ rtl/rc_pulse_width_capture_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pulse_width_capture_core
// Multi-channel rc servo pulse decoder with clamped width capture.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries events: in_tuser selects a pin change or a timer overflow,
//   in_tdata holds the pin levels and the timer timestamp of a pin change.
//   Each accepted event produces exactly one transaction on out_*, holding
//   the three channel widths and the enable flag after the event's update.
//   cfg_* writes neutral width and clamp limits; write only while idle.
// Output: each result is registered in out_data_r, or in the skid register during a stall.
// Throughput: one event per cycle while in_tready is high; the state update for an event is a
//   single pass of subtract, shift and clamp per channel.
// Stall: an output register plus a one-entry skid register hold results;
//   in_tready drops only while the skid register is occupied.
// Reset: rst_n (synchronous) restores the register defaults, sets every
//   width to the neutral default, clears pulse starts, pin history,
//   enable and activity, and empties the output side.
// ----------------------------------------------------------------------------
module rc_pulse_width_capture_core #(
  parameter int CHANNELS = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [rcpw_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [rcpw_pkg::WIDTH_BITS-1:0]      cfg_wdata,
  // event input
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [rcpw_pkg::IN_TDATA_BITS-1:0]   in_tdata,  // pin_levels[2:0], timestamp[18:3]
  input  logic                                 in_tuser,  // mode
  // result output
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [rcpw_pkg::OUT_TDATA_BITS-1:0]  out_tdata  // width_ch0, width_ch1, width_ch2, enabled
);

  import rcpw_pkg::*;

  // configuration
  width_t neutral_r;
  width_t clamp_min_r;
  width_t clamp_max_r;

  // decoder state
  logic [TS_BITS-1:0]  start_r   [CHANNELS];
  logic [TS_BITS-1:0]  start_nxt [CHANNELS];
  width_t              width_r   [CHANNELS];
  width_t              width_nxt [CHANNELS];
  logic [PIN_BITS-1:0] prev_pins_r;
  logic [PIN_BITS-1:0] prev_pins_nxt;
  logic                enable_r;
  logic                enable_nxt;
  logic                activity_r;
  logic                activity_nxt;

  // output side
  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_data_r;
  result_t skid_data_r;
  result_t result;

  logic                accept;
  logic                ev_mode;
  logic [PIN_BITS-1:0] ev_pins;
  logic [TS_BITS-1:0]  ev_ts;

  // pins padded with zeros so channels past the pin bits never see an edge
  logic [CHANNELS+PIN_BITS-1:0] pins_pad;
  logic [CHANNELS+PIN_BITS-1:0] changed_pad;
  width_t                       width_pad [CHANNELS+OUT_WIDTHS];

  logic [TS_BITS-1:0]    diff    [CHANNELS];
  logic [WIDTH_BITS-1:0] half    [CHANNELS];
  width_t                clamped [CHANNELS];

  assign in_tready = !skid_valid_r;
  assign accept    = in_tvalid && in_tready;

  assign ev_mode = in_tuser;
  assign ev_pins = in_tdata[PIN_BITS-1:0];
  assign ev_ts   = in_tdata[PIN_BITS+TS_BITS-1:PIN_BITS];

  assign pins_pad    = {{CHANNELS{1'b0}}, ev_pins};
  assign changed_pad = {{CHANNELS{1'b0}}, ev_pins ^ prev_pins_r};

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      diff[i] = ev_ts - start_r[i];
      half[i] = diff[i][TS_BITS-1:1];
      if (half[i] < clamp_min_r) begin
        clamped[i] = clamp_min_r;
      end else if (half[i] > clamp_max_r) begin
        clamped[i] = clamp_max_r;
      end else begin
        clamped[i] = half[i];
      end
    end
  end

  always_comb begin
    prev_pins_nxt = prev_pins_r;
    enable_nxt    = enable_r;
    activity_nxt  = activity_r;
    for (int i = 0; i < CHANNELS; i++) begin
      start_nxt[i] = start_r[i];
      width_nxt[i] = width_r[i];
    end
    if (ev_mode == MODE_OVERFLOW) begin
      if (activity_r) begin
        enable_nxt = 1'b1;
      end else begin
        enable_nxt = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
          width_nxt[i] = neutral_r;
        end
      end
      activity_nxt = 1'b0;
    end else begin
      activity_nxt = 1'b1;
      // while disabled the pin history is left alone
      if (enable_r) begin
        prev_pins_nxt = ev_pins;
        for (int i = 0; i < CHANNELS; i++) begin
          if (changed_pad[i]) begin
            if (pins_pad[i]) begin
              start_nxt[i] = ev_ts;
            end else begin
              width_nxt[i] = clamped[i];
            end
          end
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < CHANNELS + OUT_WIDTHS; k++) begin
      width_pad[k] = neutral_r;
    end
    for (int k = 0; k < CHANNELS; k++) begin
      width_pad[k] = width_nxt[k];
    end
    result.width_ch0 = width_pad[0];
    result.width_ch1 = width_pad[1];
    result.width_ch2 = width_pad[2];
    result.enabled   = enable_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neutral_r   <= NEUTRAL_RST;
      clamp_min_r <= CLAMP_MIN_RST;
      clamp_max_r <= CLAMP_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_NEUTRAL_WIDTH: neutral_r   <= cfg_wdata;
        CFG_CLAMP_MIN:     clamp_min_r <= cfg_wdata;
        CFG_CLAMP_MAX:     clamp_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pins_r <= '0;
      enable_r    <= 1'b0;
      activity_r  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        start_r[i] <= '0;
        width_r[i] <= NEUTRAL_RST;
      end
    end else if (accept) begin
      prev_pins_r <= prev_pins_nxt;
      enable_r    <= enable_nxt;
      activity_r  <= activity_nxt;
      for (int i = 0; i < CHANNELS; i++) begin
        start_r[i] <= start_nxt[i];
        width_r[i] <= width_nxt[i];
      end
    end
  end

  // output register with a one-entry skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (accept) begin
        out_data_r <= result;
      end
    end else if (accept) begin
      skid_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_BITS-RESULT_BITS){1'b0}}, out_data_r};

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while output register is empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    accept && out_valid_r && !out_tready |=> skid_valid_r)
    else $error("transaction taken during output stall was not kept in skid register");

  a_loss_disables: assert property (@(posedge clk) disable iff (!rst_n)
    accept && ev_mode == MODE_OVERFLOW && !activity_r |=> !enable_r && !activity_r)
    else $error("overflow without activity did not disable the decoder");

  a_enable_from_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(enable_r) |-> $past(accept && ev_mode == MODE_OVERFLOW && activity_r))
    else $error("enable set without an overflow after activity");
`endif

endmodule
